@@ design/quad_corner_order_core_macros.svh @@
// Assertion macros for the quad corner order core.
`ifndef QUAD_CORNER_ORDER_CORE_MACROS_SVH
`define QUAD_CORNER_ORDER_CORE_MACROS_SVH
// Assert that a implies b on the next clock edge.
`define QCO_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
// Assert that a implies b on the same clock edge.
`define QCO_ASSERT_SAME(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`endif

@@ design/qco_pkg.sv @@
`timescale 1ns / 1ps
package qco_pkg;
  localparam int CoordBitsDef = 12;
  localparam int CfgIdxBits   = 2;
  localparam int CfgDataBits  = 13;
  localparam int DivSteps     = 11;

  localparam logic [CfgIdxBits-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegLimit  = 2'd2;

  localparam logic [12:0] WidthRst  = 13'd640;
  localparam logic [12:0] HeightRst = 13'd480;
  localparam logic [11:0] LimitRst  = 12'd400;

  typedef struct packed {
    logic [CoordBitsDef-1:0] corner0_x;
    logic [CoordBitsDef-1:0] corner0_y;
    logic [CoordBitsDef-1:0] corner1_x;
    logic [CoordBitsDef-1:0] corner1_y;
    logic [CoordBitsDef-1:0] corner2_x;
    logic [CoordBitsDef-1:0] corner2_y;
    logic [CoordBitsDef-1:0] corner3_x;
    logic [CoordBitsDef-1:0] corner3_y;
  } qco_in_t;

  typedef struct packed {
    logic [CoordBitsDef-1:0] top_left_x;
    logic [CoordBitsDef-1:0] top_left_y;
    logic [CoordBitsDef-1:0] top_right_x;
    logic [CoordBitsDef-1:0] top_right_y;
    logic [CoordBitsDef-1:0] bottom_left_x;
    logic [CoordBitsDef-1:0] bottom_left_y;
    logic [CoordBitsDef-1:0] bottom_right_x;
    logic [CoordBitsDef-1:0] bottom_right_y;
    logic [1:0]              chosen_pairing;
    logic [1:0]              valid_pairings;
  } qco_out_t;

  // Corner indexes of each pairing: line a0-a1, line b0-b1.
  function automatic logic [1:0] pair_idx(input logic [1:0] p, input logic [1:0] k);
    logic [1:0] r;
    r = 2'd0;
    case (p)
      2'd0: r = k;
      2'd1: r = (k == 2'd0) ? 2'd0 : (k == 2'd1) ? 2'd2 : (k == 2'd2) ? 2'd1 : 2'd3;
      default: r = (k == 2'd0) ? 2'd0 : (k == 2'd1) ? 2'd3 : (k == 2'd2) ? 2'd1 : 2'd2;
    endcase
    return r;
  endfunction
endpackage

@@ design/quad_corner_order_core.sv @@
`timescale 1ns / 1ps
// quad_corner_order_core: orders four quadrilateral corners.
// Throughput: one transaction per cycle; busy is always low.
// The receiver cannot stall, so results flow out on done_o unconditionally.
// Reset (rst_ni low, asynchronous) clears the pipeline valids and restores
// registers to width 640, height 480, limit 400.
module quad_corner_order_core import qco_pkg::*; #(
  parameter int CoordBits = CoordBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  qco_in_t                in_i,
  output logic                   done_o,
  output qco_out_t               out_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);
  // Pairing units: products, terms, signs, DivSteps divides, range, square, compare.
  localparam int Lat = DivSteps + 6;

  // Configuration registers: always ready, writes land at once.
  logic [12:0] width_q, height_q;
  logic [11:0] limit_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthRst; height_q <= HeightRst; limit_q <= LimitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        RegWidth:  width_q  <= cfg_data_i;
        RegHeight: height_q <= cfg_data_i;
        RegLimit:  limit_q  <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;
  logic adv;
  assign adv = 1'b1;

  // Unpack corners, masked to the coordinate width.
  logic [CoordBits-1:0] cx [4];
  logic [CoordBits-1:0] cy [4];
  assign cx[0] = CoordBits'(in_i.corner0_x); assign cy[0] = CoordBits'(in_i.corner0_y);
  assign cx[1] = CoordBits'(in_i.corner1_x); assign cy[1] = CoordBits'(in_i.corner1_y);
  assign cx[2] = CoordBits'(in_i.corner2_x); assign cy[2] = CoordBits'(in_i.corner2_y);
  assign cx[3] = CoordBits'(in_i.corner3_x); assign cy[3] = CoordBits'(in_i.corner3_y);

  // Three pairing testers side by side.
  logic [2:0] ok;
  for (genvar p = 0; p < 3; p++) begin : g_pair
    localparam logic [1:0] I0 = pair_idx(2'(p), 2'd0);
    localparam logic [1:0] I1 = pair_idx(2'(p), 2'd1);
    localparam logic [1:0] I2 = pair_idx(2'(p), 2'd2);
    localparam logic [1:0] I3 = pair_idx(2'(p), 2'd3);
    qco_pairing #(.CoordBits(CoordBits)) u_pair (
      .clk_i, .adv_i(adv),
      .ax_i(cx[I0]), .ay_i(cy[I0]), .bx_i(cx[I1]), .by_i(cy[I1]),
      .cx_i(cx[I2]), .cy_i(cy[I2]), .dx_i(cx[I3]), .dy_i(cy[I3]),
      .width_i(width_q), .height_i(height_q), .limit_i(limit_q),
      .ok_o(ok[p])
    );
  end

  // Delay line for the corners and the valid bit, matched to the testers.
  logic [8*CoordBits-1:0] pts_q [Lat];
  logic [Lat-1:0]         vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end
  always_ff @(posedge clk_i) begin
    pts_q[0] <= {cx[0], cy[0], cx[1], cy[1], cx[2], cy[2], cx[3], cy[3]};
    for (int k = 1; k < Lat; k++) pts_q[k] <= pts_q[k-1];
  end

  // Final stage: pick the last valid pairing (pairing 0 if none), order the lines.
  logic [CoordBits-1:0] fx [4];
  logic [CoordBits-1:0] fy [4];
  for (genvar k = 0; k < 4; k++) begin : g_unp
    assign fx[k] = pts_q[Lat-1][(7-2*k)*CoordBits +: CoordBits];
    assign fy[k] = pts_q[Lat-1][(6-2*k)*CoordBits +: CoordBits];
  end

  qco_out_t res_q;
  logic     done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= vld_q[Lat-1];
  end
  always_ff @(posedge clk_i) begin
    logic [1:0] ch;
    logic [1:0] a0, a1, b0, b1, t;
    ch = ok[2] ? 2'd2 : ok[1] ? 2'd1 : 2'd0;
    a0 = pair_idx(ch, 2'd0); a1 = pair_idx(ch, 2'd1);
    b0 = pair_idx(ch, 2'd2); b1 = pair_idx(ch, 2'd3);
    if (fy[a0] > fy[a1]) begin t = a0; a0 = a1; a1 = t; end
    if (fy[b0] > fy[b1]) begin t = b0; b0 = b1; b1 = t; end
    if (fx[a0] >= fx[b0]) begin
      t = a0; a0 = b0; b0 = t; t = a1; a1 = b1; b1 = t;
    end
    res_q.top_left_x     <= CoordBitsDef'(fx[a0]);
    res_q.top_left_y     <= CoordBitsDef'(fy[a0]);
    res_q.top_right_x    <= CoordBitsDef'(fx[b0]);
    res_q.top_right_y    <= CoordBitsDef'(fy[b0]);
    res_q.bottom_left_x  <= CoordBitsDef'(fx[a1]);
    res_q.bottom_left_y  <= CoordBitsDef'(fy[a1]);
    res_q.bottom_right_x <= CoordBitsDef'(fx[b1]);
    res_q.bottom_right_y <= CoordBitsDef'(fy[b1]);
    res_q.chosen_pairing <= ch;
    res_q.valid_pairings <= 2'({1'b0, ok[0]} + {1'b0, ok[1]} + {1'b0, ok[2]});
  end
  assign done_o = done_q;
  assign out_o  = res_q;
endmodule

@@ design/qco_pairing.sv @@
`timescale 1ns / 1ps
// One pairing test: intersect two lines, truncate, range and distance check.
// Pipeline: products, numerators, signs, divider steps, range, distance, compare.
module qco_pairing import qco_pkg::*; #(
  parameter int CoordBits = CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  logic [CoordBits-1:0] ax_i, ay_i, bx_i, by_i, cx_i, cy_i, dx_i, dy_i,
  input  logic [12:0]          width_i,
  input  logic [12:0]          height_i,
  input  logic [11:0]          limit_i,
  output logic                 ok_o
);
  localparam int DB  = CoordBits + 2;
  localparam int PB  = 2 * CoordBits + 3;
  localparam int NB  = 3 * CoordBits + 6;
  localparam int QB  = NB;
  localparam int StepBits = (QB + DivSteps - 1) / DivSteps;
  localparam int TotBits  = StepBits * DivSteps;

  // stage 1: differences and cross products
  logic signed [DB-1:0] dxab_q, dyab_q, dxcd_q, dycd_q;
  logic signed [PB-1:0] cab_q, ccd_q;
  logic [CoordBits-1:0] p_q [8];
  logic signed [DB-1:0] dxab_d, dyab_d, dxcd_d, dycd_d;
  assign dxab_d = $signed({2'b0, ax_i}) - $signed({2'b0, bx_i});
  assign dyab_d = $signed({2'b0, ay_i}) - $signed({2'b0, by_i});
  assign dxcd_d = $signed({2'b0, cx_i}) - $signed({2'b0, dx_i});
  assign dycd_d = $signed({2'b0, cy_i}) - $signed({2'b0, dy_i});
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dxab_q <= dxab_d; dyab_q <= dyab_d; dxcd_q <= dxcd_d; dycd_q <= dycd_d;
      cab_q <= PB'($signed({1'b0, ax_i}) * $signed({1'b0, by_i}))
             - PB'($signed({1'b0, ay_i}) * $signed({1'b0, bx_i}));
      ccd_q <= PB'($signed({1'b0, cx_i}) * $signed({1'b0, dy_i}))
             - PB'($signed({1'b0, cy_i}) * $signed({1'b0, dx_i}));
      p_q[0] <= ax_i; p_q[1] <= ay_i; p_q[2] <= bx_i; p_q[3] <= by_i;
      p_q[4] <= cx_i; p_q[5] <= cy_i; p_q[6] <= dx_i; p_q[7] <= dy_i;
    end
  end

  // stage 2: product terms
  logic signed [PB-1:0] den0_q, den1_q;
  logic signed [NB-1:0] nx0_q, nx1_q, ny0_q, ny1_q;
  logic [CoordBits-1:0] p2_q [8];
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den0_q <= PB'(dycd_q * dxab_q);
      den1_q <= PB'(dxcd_q * dyab_q);
      nx0_q  <= NB'(cab_q * dxcd_q);
      nx1_q  <= NB'(dxab_q * ccd_q);
      ny0_q  <= NB'(cab_q * dycd_q);
      ny1_q  <= NB'(dyab_q * ccd_q);
      p2_q   <= p_q;
    end
  end

  // stage 3: magnitudes and signs
  logic [PB-1:0] dmag_q;
  logic [NB-1:0] nxm_q, nym_q;
  logic          nzero_q, sx_q, sy_q;
  logic [CoordBits-1:0] p3_q [8];
  logic signed [PB-1:0] den_w;
  logic signed [NB-1:0] nx_w, ny_w;
  assign den_w = den0_q - den1_q;
  assign nx_w  = nx0_q - nx1_q;
  assign ny_w  = ny0_q - ny1_q;
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dmag_q  <= den_w[PB-1] ? PB'(-den_w) : den_w;
      nxm_q   <= nx_w[NB-1] ? NB'(-nx_w) : nx_w;
      nym_q   <= ny_w[NB-1] ? NB'(-ny_w) : ny_w;
      nzero_q <= (den_w != '0);
      sx_q    <= nx_w[NB-1] ^ den_w[PB-1];
      sy_q    <= ny_w[NB-1] ^ den_w[PB-1];
      p3_q    <= p2_q;
    end
  end

  // divider stages: restoring, StepBits quotient bits per stage, two lanes
  logic [TotBits-1:0] qx_s [DivSteps+1];
  logic [TotBits-1:0] qy_s [DivSteps+1];
  logic [PB:0]        rx_s [DivSteps+1];
  logic [PB:0]        ry_s [DivSteps+1];
  logic [PB-1:0]      dv_s [DivSteps+1];
  logic               nz_s [DivSteps+1];
  logic               sx_s [DivSteps+1];
  logic               sy_s [DivSteps+1];
  logic [CoordBits-1:0] pd_s [DivSteps+1][8];
  assign qx_s[0] = TotBits'(nxm_q);
  assign qy_s[0] = TotBits'(nym_q);
  assign rx_s[0] = '0;
  assign ry_s[0] = '0;
  assign dv_s[0] = dmag_q;
  assign nz_s[0] = nzero_q;
  assign sx_s[0] = sx_q;
  assign sy_s[0] = sy_q;
  assign pd_s[0] = p3_q;

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    logic [TotBits-1:0] qx_c, qy_c;
    logic [PB:0]        rx_c, ry_c;
    always_comb begin
      logic [PB+1:0] tx, ty;
      qx_c = qx_s[g]; qy_c = qy_s[g]; rx_c = rx_s[g]; ry_c = ry_s[g];
      for (int k = 0; k < StepBits; k++) begin
        tx = {rx_c, qx_c[TotBits-1]};
        ty = {ry_c, qy_c[TotBits-1]};
        qx_c = {qx_c[TotBits-2:0], 1'b0};
        qy_c = {qy_c[TotBits-2:0], 1'b0};
        if (tx >= {2'b0, dv_s[g]}) begin
          tx = tx - {2'b0, dv_s[g]}; qx_c[0] = 1'b1;
        end
        if (ty >= {2'b0, dv_s[g]}) begin
          ty = ty - {2'b0, dv_s[g]}; qy_c[0] = 1'b1;
        end
        rx_c = tx[PB:0];
        ry_c = ty[PB:0];
      end
    end
    logic [TotBits-1:0] qx_q, qy_q;
    logic [PB:0]        rx_q, ry_q;
    logic [PB-1:0]      dv_q;
    logic               nz_q, sxq_q, syq_q;
    logic [CoordBits-1:0] pd_q [8];
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        qx_q <= qx_c; qy_q <= qy_c; rx_q <= rx_c; ry_q <= ry_c;
        dv_q <= dv_s[g]; nz_q <= nz_s[g]; sxq_q <= sx_s[g]; syq_q <= sy_s[g];
        pd_q <= pd_s[g];
      end
    end
    assign qx_s[g+1] = qx_q;
    assign qy_s[g+1] = qy_q;
    assign rx_s[g+1] = rx_q;
    assign ry_s[g+1] = ry_q;
    assign dv_s[g+1] = dv_q;
    assign nz_s[g+1] = nz_q;
    assign sx_s[g+1] = sxq_q;
    assign sy_s[g+1] = syq_q;
    assign pd_s[g+1] = pd_q;
  end

  // range stage: quotient magnitude is below 2^13 when inside, the test fails otherwise
  localparam int SB = 15;
  localparam int S2 = 2 * SB;
  logic [TotBits-1:0] qxm, qym;
  logic               bigx, bigy;
  assign qxm  = qx_s[DivSteps];
  assign qym  = qy_s[DivSteps];
  assign bigx = (qxm >> 13) != '0;
  assign bigy = (qym >> 13) != '0;
  logic              okr_q;
  logic signed [SB-1:0] ddx_q [4];
  logic signed [SB-1:0] ddy_q [4];
  always_ff @(posedge clk_i) begin
    logic signed [SB-1:0] px, py;
    if (adv_i) begin
      px = $signed({2'b0, qxm[12:0]});
      py = $signed({2'b0, qym[12:0]});
      okr_q <= nz_s[DivSteps] && !bigx && !bigy && !sx_s[DivSteps]
            && !sy_s[DivSteps] && (qxm[12:0] != '0) && (qym[12:0] != '0)
            && ({1'b0, qxm[12:0]} + 14'd1 < {1'b0, width_i})
            && ({1'b0, qym[12:0]} + 14'd1 < {1'b0, height_i});
      for (int j = 0; j < 4; j++) begin
        ddx_q[j] <= px - $signed(SB'(pd_s[DivSteps][2*j]));
        ddy_q[j] <= py - $signed(SB'(pd_s[DivSteps][2*j+1]));
      end
    end
  end

  // distance stage: squares
  logic [S2-1:0] d2_q [4];
  logic          okd_q;
  always_ff @(posedge clk_i) begin
    logic signed [S2-1:0] ex, ey;
    if (adv_i) begin
      for (int j = 0; j < 4; j++) begin
        ex = S2'(ddx_q[j]);
        ey = S2'(ddy_q[j]);
        d2_q[j] <= $unsigned(ex * ex + ey * ey);
      end
      okd_q <= okr_q;
    end
  end

  // compare stage against limit squared
  logic [23:0] lim2;
  assign lim2 = limit_i * limit_i;
  logic ok_q;
  always_ff @(posedge clk_i) begin
    logic ok;
    if (adv_i) begin
      ok = okd_q;
      for (int j = 0; j < 4; j++) begin
        if (d2_q[j] > S2'(lim2)) ok = 1'b0;
      end
      ok_q <= ok;
    end
  end
  assign ok_o = ok_q;
endmodule

@@ design/qco_checker.sv @@
`timescale 1ns / 1ps
`include "quad_corner_order_core_macros.svh"
module qco_checker import qco_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     busy,
  input logic     done_o,
  input qco_out_t out_o,
  input logic     cfg_ready_o
);
  `QCO_ASSERT_SAME(a_busy_low, clk_i, rst_ni, 1'b1, !busy)
  `QCO_ASSERT_SAME(a_cfg_rdy, clk_i, rst_ni, 1'b1, cfg_ready_o)
  `QCO_ASSERT_SAME(a_pair_rng, clk_i, rst_ni, done_o, out_o.chosen_pairing != 2'd3)
  `QCO_ASSERT_SAME(a_none_zero, clk_i, rst_ni, done_o && out_o.valid_pairings == 2'd0,
    out_o.chosen_pairing == 2'd0)
  `QCO_ASSERT_NEXT(a_idle, clk_i, rst_ni, !rst_ni, !done_o)
endmodule

bind quad_corner_order_core qco_checker u_qco_checker (
  .clk_i, .rst_ni, .busy, .done_o, .out_o, .cfg_ready_o
);
